>>> sv/tms_pkg.sv
// Package: constants, command codes, payload structs and FSM states for the matrix stack.
package tms_pkg;

    localparam int StackDepth = 32;
    localparam int FracBits   = 16;
    localparam int LevelW     = $clog2(StackDepth);
    localparam int MemDepth   = StackDepth * 16;
    localparam int MemAw      = $clog2(MemDepth);
    localparam logic signed [31:0] One = 32'sd1 <<< FracBits;

    typedef enum logic [3:0] {
        REQ_PUSH    = 4'd0,
        REQ_POP     = 4'd1,
        REQ_TRANS   = 4'd2,
        REQ_SCALE   = 4'd3,
        REQ_ROTX    = 4'd4,
        REQ_ROTY    = 4'd5,
        REQ_ROTZ    = 4'd6,
        REQ_MUL     = 4'd7,
        REQ_REPLACE = 4'd8,
        REQ_WROP    = 4'd9,
        REQ_READ    = 4'd10
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_LAST      = 2'd2
    } t_status;

    typedef struct packed {
        logic [3:0]         req_type;
        logic signed [31:0] val_a;
        logic signed [31:0] val_b;
        logic signed [31:0] val_c;
        logic [3:0]         elem_index;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_data;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COPY,
        S_LOAD,
        S_MAC,
        S_WB,
        S_READ,
        S_DONE
    } t_state;

    // Identity element value at row*4+col.
    function automatic logic signed [31:0] ident(input logic [3:0] i);
        ident = (i[3:2] == i[1:0]) ? One : 32'sd0;
    endfunction

endpackage

>>> sv/transform_matrix_stack_core.sv
// Top level: command sequencer around the matrix store RAM and the dot-product unit.
//
// One command per transaction; busy is high from acceptance until the
// result strobe. Push copies 16 words through the single RAM port;
// multiplies form each of the 16 result elements as a 4-term dot product,
// one product per cycle, with the row of the top matrix held in registers:
// each row is loaded, its four elements are formed, and the row is written
// back. Replace writes 16 words and read fetches one word. The result is
// presented for one cycle on o_done and cannot be stalled.
module transform_matrix_stack_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  tms_pkg::t_in    i_req,
    output logic            o_done,
    output tms_pkg::t_out   o_res
);
    import tms_pkg::*;

    t_state r_state, n_state;
    t_in    r_cmd;
    logic [LevelW-1:0] r_lvl, n_lvl;
    logic [4:0] r_cnt, n_cnt;
    logic [2:0] r_k;
    logic [1:0] r_st;
    logic signed [31:0] r_rd;
    logic signed [31:0] r_op [16];
    logic signed [31:0] r_row [4];
    logic r_init;
    logic [4:0] r_icnt;

    logic             w_we;
    logic [MemAw-1:0] w_addr;
    logic [31:0]      w_wdata, w_rdata;
    logic [LevelW-1:0] w_lvl_mem;
    logic [3:0]       w_ei;
    logic             w_clr, w_en;
    logic signed [31:0] w_t, w_res;
    logic signed [32:0] w_b;
    logic [3:0] w_bi;
    logic       w_mul;

    tms_ram #(.Width(32), .Depth(MemDepth)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
        .i_wdata(w_wdata), .o_rdata(w_rdata)
    );

    tms_dot u_dot (
        .i_clk(i_clk), .i_clr(w_clr), .i_en(w_en),
        .i_t(w_t), .i_b(w_b), .o_res(w_res)
    );

    assign busy = (r_state != S_IDLE) || r_init;
    assign w_mul = (r_cmd.req_type >= REQ_TRANS) && (r_cmd.req_type <= REQ_MUL);

    // S_MAC: r_cnt = result element (row,col); r_k = term 0..3, 4..5 drain.
    // S_LOAD: r_cnt[3:2] selects the row of the current element; r_k counts the reads.
    assign w_bi = {r_k[1:0], r_cnt[1:0]};
    assign w_t  = r_row[r_k[1:0]];

    always_comb begin
        logic signed [32:0] a, b, c, nb;
        a  = 33'(r_cmd.val_a);
        b  = 33'(r_cmd.val_b);
        c  = 33'(r_cmd.val_c);
        nb = -b;
        w_b = 33'(ident(w_bi));
        unique case (r_cmd.req_type)
            REQ_TRANS: begin
                if (w_bi == 4'd12) w_b = a;
                if (w_bi == 4'd13) w_b = b;
                if (w_bi == 4'd14) w_b = c;
            end
            REQ_SCALE: begin
                if (w_bi == 4'd0)  w_b = a;
                if (w_bi == 4'd5)  w_b = b;
                if (w_bi == 4'd10) w_b = c;
            end
            REQ_ROTX: begin
                if (w_bi == 4'd5 || w_bi == 4'd10) w_b = a;
                if (w_bi == 4'd6) w_b = nb;
                if (w_bi == 4'd9) w_b = b;
            end
            REQ_ROTY: begin
                if (w_bi == 4'd0 || w_bi == 4'd10) w_b = a;
                if (w_bi == 4'd2) w_b = b;
                if (w_bi == 4'd8) w_b = nb;
            end
            REQ_ROTZ: begin
                if (w_bi == 4'd0 || w_bi == 4'd5) w_b = a;
                if (w_bi == 4'd1) w_b = nb;
                if (w_bi == 4'd4) w_b = b;
            end
            REQ_MUL: w_b = 33'(r_op[w_bi]);
            default: ;
        endcase
    end

    // Result row i is written back after all 4 columns; row i of the top is
    // reloaded per row, so in-place writeback of earlier rows is safe.
    logic signed [31:0] r_res [4];

    always_comb begin
        n_state = r_state;
        n_lvl   = r_lvl;
        n_cnt   = r_cnt;
        w_we    = 1'b0;
        w_lvl_mem = r_lvl;
        w_ei    = r_cnt[3:0];
        w_wdata = w_rdata;
        w_clr   = 1'b0;
        w_en    = 1'b0;
        if (r_init) begin
            w_we = 1'b1;
            w_lvl_mem = '0;
            w_ei = r_icnt[3:0];
            w_wdata = ident(r_icnt[3:0]);
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    w_ei = i_req.elem_index;
                    if (start) begin
                        n_cnt = '0;
                        priority case (i_req.req_type)
                            REQ_PUSH: n_state = (32'(r_lvl) + 1 >= StackDepth) ? S_DONE : S_COPY;
                            REQ_POP: begin
                                n_state = S_DONE;
                                if (r_lvl != '0) n_lvl = r_lvl - 1'b1;
                            end
                            REQ_TRANS, REQ_SCALE, REQ_ROTX, REQ_ROTY, REQ_ROTZ, REQ_MUL:
                                n_state = S_LOAD;
                            REQ_REPLACE: n_state = S_WB;
                            REQ_READ: n_state = S_READ;
                            default: n_state = S_DONE;
                        endcase
                    end
                end
                S_COPY: begin
                    // even count: read word; odd: write it one level up
                    w_ei = r_cnt[4:1];
                    if (r_cnt[0]) begin
                        w_we = 1'b1;
                        w_lvl_mem = r_lvl + 1'b1;
                    end
                    n_cnt = r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        n_state = S_DONE;
                        n_lvl = r_lvl + 1'b1;
                    end
                end
                S_LOAD: begin
                    // r_cnt[3:2]=row index; r_k counts reads 0..4
                    w_ei = {r_cnt[3:2], r_k[1:0]};
                    if (r_k == 3'd4) begin
                        n_state = S_MAC;
                        w_clr = 1'b1;
                    end
                end
                S_MAC: begin
                    w_en = (r_k < 3'd4);
                    if (r_k == 3'd5) begin
                        // clear for the next element once this one is taken
                        w_clr = 1'b1;
                        n_cnt = r_cnt + 5'd1;
                        if (r_cnt[1:0] == 2'd3) begin
                            n_state = S_WB;
                        end
                    end
                end
                S_WB: begin
                    w_we = 1'b1;
                    if (w_mul) begin
                        // writes row r_cnt[3:2]-1, columns via r_k
                        w_ei = {2'(r_cnt[3:2] - 2'd1), r_k[1:0]};
                        w_wdata = r_res[r_k[1:0]];
                        if (r_k == 3'd3) n_state = (r_cnt == 5'd16) ? S_DONE : S_LOAD;
                    end else begin
                        w_ei = r_cnt[3:0];
                        w_wdata = r_op[r_cnt[3:0]];
                        n_cnt = r_cnt + 5'd1;
                        if (r_cnt == 5'd15) n_state = S_DONE;
                    end
                end
                S_READ: n_state = S_DONE;
                S_DONE: n_state = S_IDLE;
                default: n_state = S_IDLE;
            endcase
        end
        w_addr = {w_lvl_mem, w_ei};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lvl   <= '0;
            r_init  <= 1'b1;
            r_icnt  <= '0;
            r_k     <= '0;
            r_cnt   <= '0;
            for (int i = 0; i < 16; i++) r_op[i] <= ident(4'(i));
        end else begin
            r_state <= n_state;
            r_lvl   <= n_lvl;
            r_cnt   <= n_cnt;
            if (r_init) begin
                r_icnt <= r_icnt + 5'd1;
                if (r_icnt == 5'd15) r_init <= 1'b0;
            end
            if (r_state == S_IDLE && start && !busy) begin
                r_cmd <= i_req;
                r_rd  <= '0;
                r_k   <= '0;
                if (i_req.req_type == REQ_PUSH && 32'(r_lvl) + 1 >= StackDepth) begin
                    r_st <= ST_FULL;
                end else if (i_req.req_type == REQ_POP && r_lvl == '0) begin
                    r_st <= ST_LAST;
                end else begin
                    r_st <= ST_DONE;
                end
                if (i_req.req_type == REQ_WROP) r_op[i_req.elem_index] <= i_req.val_a;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (r_k != 3'd0) r_row[r_k[1:0] - 2'd1] <= w_rdata;
                    r_k <= (r_k == 3'd4) ? 3'd0 : r_k + 3'd1;
                end
                S_MAC: begin
                    if (r_k == 3'd5) begin
                        r_res[r_cnt[1:0]] <= w_res;
                        r_k <= '0;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_WB: if (w_mul) r_k <= (r_k == 3'd3) ? 3'd0 : r_k + 3'd1;
                S_READ: r_rd <= w_rdata;
                default: ;
            endcase
        end
    end

    assign o_done = (r_state == S_DONE);
    assign o_res.status = r_st;
    assign o_res.read_data = o_done ? r_rd : 32'sd0;

`ifndef SYNTHESIS
    a_idle_nobusy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy || r_init) else $error("busy after done");
    a_lvl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_lvl) < StackDepth) else $error("level out of range");
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
    a_no_init_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> r_state == S_IDLE) else $error("work during init");
`endif
endmodule

>>> sv/tms_ram.sv
// Generic single-port RAM with registered read.
module tms_ram #(
    parameter int Width = 32,
    parameter int Depth = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

>>> sv/tms_dot.sv
// One-product-per-cycle accumulator with shift/saturate; the elements of B are built in the core.
module tms_dot (
    input  logic                    i_clk,
    input  logic                    i_clr,
    input  logic                    i_en,
    input  logic signed [31:0]      i_t,
    input  logic signed [32:0]      i_b,
    output logic signed [31:0]      o_res
);
    import tms_pkg::*;

    logic signed [65:0] r_p;
    logic               r_pv;
    logic signed [67:0] r_acc;
    logic signed [67:0] n_acc;
    logic signed [67:0] w_sh;

    always_ff @(posedge i_clk) begin
        r_p  <= 66'(i_t * i_b);
        r_pv <= i_en;
        r_acc <= n_acc;
    end

    always_comb begin
        n_acc = r_acc;
        if (i_clr) begin
            n_acc = '0;
        end else if (r_pv) begin
            n_acc = r_acc + 68'(r_p);
        end
    end

    // exact sum, then an arithmetic (floor) shift and saturation to 32 bits
    assign w_sh = r_acc >>> FracBits;
    always_comb begin
        if (w_sh > 68'sd2147483647) begin
            o_res = 32'sh7fffffff;
        end else if (w_sh < -68'sd2147483648) begin
            o_res = 32'sh80000000;
        end else begin
            o_res = w_sh[31:0];
        end
    end
endmodule
